@@ hdl/ffba_pkg.sv @@
`default_nettype none
package ffba_pkg;

   localparam int NUM_BLOCKS  = 256;
   localparam int BLOCK_SHIFT = 12;
   localparam int BLOCK_SIZE  = 1 << BLOCK_SHIFT;
   localparam int CNT_W       = $clog2(NUM_BLOCKS);
   localparam int NEED_W      = 33 - BLOCK_SHIFT;
   localparam logic [32:0] HEAP_BYTES = 33'(NUM_BLOCKS) << BLOCK_SHIFT;

   // block table entry bits
   localparam int MARK_TAKEN = 0;
   localparam int MARK_FIRST = 1;
   localparam int MARK_NEXT  = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_ZERO     = 3'd1;
   localparam logic [2:0] ST_NOMEM    = 3'd2;
   localparam logic [2:0] ST_RANGE    = 3'd3;
   localparam logic [2:0] ST_NOTSTART = 3'd4;

   typedef struct packed {
      logic        operation;
      logic [31:0] byte_count;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [31:0] block_address;
      logic [2:0]  status;
   } rsp_type;

endpackage
`default_nettype wire

@@ hdl/ffba_cell.sv @@
`default_nettype none
// One table entry; moves one place toward the head on each shift.
module ffba_cell (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       shift_en,
   input  wire logic [2:0] neighbor_entry,
   output logic      [2:0] entry
);

   logic [2:0] entry_ff;
   logic [2:0] entry_in;

   always_comb begin
      entry_in = shift_en ? neighbor_entry : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= 3'd0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

@@ hdl/first_fit_block_allocator.sv @@
// First-fit block allocator over a table of NUM_BLOCKS heap blocks.
// req channel (req_valid/req_stall/req_data): one word per request, either
// allocate (byte_count) or free (address). rsp channel (rsp_valid/rsp_stall/
// rsp_data): exactly one word per request, block address and status.
// csr channel (csr_valid/csr_ready/csr_data): writes heap_base; write it only
// while no request is in flight.
// The table lives in a ring of cells that rotates one entry per cycle, while
// a scan, mark or free pass runs, past a single head port. A request runs alone:
//   errors found up front (zero size, too large, bad address): no rotation
//   free: one full rotation
//   allocate: one rotation when nothing fits, else two rotations
//   (one to find the run, one to mark it).
// req_stall is high while a request is in progress. A finished response
// sits in the output register while rsp_stall is high; a new request may be
// accepted meanwhile, and its response waits until the register is free.
// Synchronous reset clears the whole table (all blocks free), heap_base and
// the response valid flag; no clearing pass is needed.
`default_nettype none
module first_fit_block_allocator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ffba_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ffba_pkg::rsp_type     rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [31:0]      csr_data
);

   localparam int N  = ffba_pkg::NUM_BLOCKS;
   localparam int CW = ffba_pkg::CNT_W;
   localparam int NW = ffba_pkg::NEED_W;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_SCAN, S_MARK, S_FREE, S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic              op_ff, op_in;
   logic [31:0]       bytes_ff, bytes_in;
   logic [31:0]       addr_ff, addr_in;
   logic [NW-1:0]     need_ff, need_in;
   logic [CW:0]       run_len_ff, run_len_in;
   logic [CW-1:0]     start_ff, start_in;
   logic              found_ff, found_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              clearing_ff, clearing_in;
   logic [2:0]        status_ff, status_in;
   logic [31:0]       result_addr_ff, result_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ffba_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [31:0]       base_ff, base_in;

   logic [2:0]        map_q [N];
   logic [2:0]        head;
   logic [2:0]        tail_in;
   logic              shift_en;
   logic              last_pos;
   logic [32:0]       need_sum;
   logic [NW-1:0]     need_calc;
   logic [31:0]       offset;
   logic [CW-1:0]     rel;
   logic              rsp_free;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         if (g == N - 1) begin : g_tail
            ffba_cell u_cell (
               .clock(clock), .reset(reset), .shift_en(shift_en),
               .neighbor_entry(tail_in), .entry(map_q[g])
            );
         end else begin : g_body
            ffba_cell u_cell (
               .clock(clock), .reset(reset), .shift_en(shift_en),
               .neighbor_entry(map_q[g+1]), .entry(map_q[g])
            );
         end
      end
   endgenerate

   assign head     = map_q[0];
   assign shift_en = (state_ff == S_SCAN) || (state_ff == S_MARK) || (state_ff == S_FREE);
   assign last_pos = (pos_ff == CW'(N - 1));
   assign need_sum = {1'b0, bytes_ff} + 33'(ffba_pkg::BLOCK_SIZE - 1);
   assign need_calc = NW'(need_sum >> ffba_pkg::BLOCK_SHIFT);
   assign offset   = addr_ff - base_ff;
   assign rel      = pos_ff - start_ff;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      op_in          = op_ff;
      bytes_in       = bytes_ff;
      addr_in        = addr_ff;
      need_in        = need_ff;
      run_len_in     = run_len_ff;
      start_in       = start_ff;
      found_in       = found_ff;
      idx_in         = idx_ff;
      clearing_in    = clearing_ff;
      status_in      = status_ff;
      result_addr_in = result_addr_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      base_in        = base_ff;
      tail_in        = head;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid) begin
         base_in = csr_data;
      end

      if (shift_en) begin
         pos_in = last_pos ? '0 : pos_ff + CW'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_data.operation;
               bytes_in    = req_data.byte_count;
               addr_in     = req_data.address;
               run_len_in  = '0;
               found_in    = 1'b0;
               clearing_in = 1'b0;
               result_addr_in = '0;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            need_in = need_calc;
            idx_in  = CW'(offset >> ffba_pkg::BLOCK_SHIFT);
            if (op_ff == ffba_pkg::OP_ALLOC) begin
               if (bytes_ff == '0) begin
                  status_in = ffba_pkg::ST_ZERO;
                  state_in  = S_FINISH;
               end else if (33'(need_calc) > 33'(N)) begin
                  status_in = ffba_pkg::ST_NOMEM;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               if (addr_ff < base_ff || {1'b0, offset} >= ffba_pkg::HEAP_BYTES) begin
                  status_in = ffba_pkg::ST_RANGE;
                  state_in  = S_FINISH;
               end else if (offset[ffba_pkg::BLOCK_SHIFT-1:0] != '0) begin
                  status_in = ffba_pkg::ST_NOTSTART;
                  state_in  = S_FINISH;
               end else begin
                  status_in = ffba_pkg::ST_NOTSTART;
                  state_in  = S_FREE;
               end
            end
         end
         S_SCAN: begin
            if (!found_ff) begin
               if (!head[ffba_pkg::MARK_TAKEN]) begin
                  if (run_len_ff == '0) begin
                     start_in = pos_ff;
                  end
                  run_len_in = run_len_ff + (CW+1)'(1);
                  if (33'(run_len_ff) + 33'd1 == 33'(need_ff)) begin
                     found_in = 1'b1;
                  end
               end else begin
                  run_len_in = '0;
               end
            end
            if (last_pos) begin
               if (found_in) begin
                  state_in = S_MARK;
               end else begin
                  status_in = ffba_pkg::ST_NOMEM;
                  state_in  = S_FINISH;
               end
            end
         end
         S_MARK: begin
            if (pos_ff >= start_ff && 33'(rel) < 33'(need_ff)) begin
               tail_in = '0;
               tail_in[ffba_pkg::MARK_TAKEN] = 1'b1;
               tail_in[ffba_pkg::MARK_FIRST] = (pos_ff == start_ff);
               tail_in[ffba_pkg::MARK_NEXT]  = (33'(rel) + 33'd1 < 33'(need_ff));
            end
            if (last_pos) begin
               status_in      = ffba_pkg::ST_OK;
               result_addr_in = base_ff + (32'(start_ff) << ffba_pkg::BLOCK_SHIFT);
               state_in       = S_FINISH;
            end
         end
         S_FREE: begin
            if (pos_ff == idx_ff) begin
               if (head[ffba_pkg::MARK_FIRST]) begin
                  tail_in     = '0;
                  clearing_in = head[ffba_pkg::MARK_NEXT];
                  status_in   = ffba_pkg::ST_OK;
               end
            end else if (clearing_ff) begin
               tail_in     = '0;
               clearing_in = head[ffba_pkg::MARK_NEXT];
            end
            if (last_pos) begin
               clearing_in = 1'b0;
               state_in    = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status        = status_ff;
               rsp_data_in.block_address =
                  (status_ff == ffba_pkg::ST_OK) ? result_addr_ff : '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         found_ff     <= 1'b0;
         clearing_ff  <= 1'b0;
         run_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         found_ff     <= found_in;
         clearing_ff  <= clearing_in;
         run_len_ff   <= run_len_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
      end
      op_ff          <= op_in;
      bytes_ff       <= bytes_in;
      addr_ff        <= addr_in;
      need_ff        <= need_in;
      start_ff       <= start_in;
      idx_ff         <= idx_in;
      status_ff      <= status_in;
      result_addr_ff <= result_addr_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   a_mark_needs_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MARK |-> found_ff)
      else $error("marking without a found run");

   a_clear_after_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FREE && clearing_ff) |-> pos_ff > idx_ff)
      else $error("release chain active before its start block");

   a_idle_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> pos_ff == '0)
      else $error("table ring out of alignment at idle");

   a_error_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ffba_pkg::ST_OK)
         |-> rsp_data_ff.block_address == '0)
      else $error("error response with nonzero address");

endmodule
`default_nettype wire
